[rtl/core/agtq_pkg.sv]
// agtq_pkg: shared types, constants and slot helper for the audio gap trim delay queue
// no dependencies; used by agtq_ctrl, agtq_dp and audio_gap_trim_delay_queue_core
`default_nettype none

package agtq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned DELAY_W = 16;

  localparam logic [DELAY_W-1:0] DELAY_RST = 16'd3000;
  localparam logic [LEVEL_W-1:0] THR_RST   = 15'd512;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_DELAY = 1'b0,
    REG_THR   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               kind;
    logic [TAG_W-1:0]   buffer_tag;
    logic [TIME_W-1:0]  time_ms;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  time_ms;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  typedef enum logic [1:0] {
    RD_HEAD   = 2'd0,
    RD_NEWEST = 2'd1,
    RD_PREV   = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    gap_ld;
    logic    rel_ld;
    logic    drop_newest;
    logic    pop_head;
    logic    head_zero;
    logic    push;
    logic    emit;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic gap;
    logic loud_item;
    logic newest_quiet;
    logic release_ok;
    logic out_free;
  } sts_t;

  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
                                               logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/agtq_ctrl.sv]
// agtq_ctrl: sequencing state machine for gap test, trim, flush, push and release
// depends on agtq_pkg; drives agtq_dp through command and status structs
`default_nettype none

module agtq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  output logic               in_ready_o,
  input  agtq_pkg::sts_t     sts_i,
  output agtq_pkg::cmd_t     cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_GAP_DIFF = 14'b00000000000010,
    S_GAP_TEST = 14'b00000000000100,
    S_TRIM     = 14'b00000000001000,
    S_FLUSH_RD = 14'b00000000010000,
    S_FLUSH_EM = 14'b00000000100000,
    S_FULL_RD  = 14'b00000001000000,
    S_FULL_EM  = 14'b00000010000000,
    S_PUSH     = 14'b00000100000000,
    S_REL_RD   = 14'b00001000000000,
    S_REL_DIFF = 14'b00010000000000,
    S_REL_TEST = 14'b00100000000000,
    S_FIN      = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = agtq_pkg::RD_HEAD;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          if (in_kind_i) begin
            cmd_o.clear = 1'b1;
          end else if (sts_i.count_zero) begin
            state_d = S_PUSH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = agtq_pkg::RD_NEWEST;
            state_d      = S_GAP_DIFF;
          end
        end
      end
      S_GAP_DIFF: begin
        cmd_o.gap_ld = 1'b1;
        state_d      = S_GAP_TEST;
      end
      S_GAP_TEST: begin
        priority if (sts_i.gap && sts_i.loud_item) begin
          state_d = S_TRIM;
        end else if (sts_i.gap) begin
          state_d = S_FIN;
        end else if (sts_i.count_full) begin
          state_d = S_FULL_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_TRIM: begin
        if (!sts_i.count_zero && sts_i.newest_quiet) begin
          cmd_o.drop_newest = 1'b1;
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_sel      = agtq_pkg::RD_PREV;
        end else begin
          state_d = S_FLUSH_RD;
        end
      end
      S_FLUSH_RD: begin
        if (sts_i.count_zero) begin
          cmd_o.head_zero = 1'b1;
          state_d         = S_PUSH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_FLUSH_EM;
        end
      end
      S_FLUSH_EM: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.pop_head = 1'b1;
          state_d        = S_FLUSH_RD;
        end
      end
      S_FULL_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FULL_EM;
      end
      S_FULL_EM: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.pop_head = 1'b1;
          state_d        = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_REL_RD;
      end
      S_REL_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_REL_DIFF;
      end
      S_REL_DIFF: begin
        cmd_o.rel_ld = 1'b1;
        state_d      = S_REL_TEST;
      end
      S_REL_TEST: begin
        if (sts_i.release_ok && !sts_i.count_zero) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.pop_head = 1'b1;
            state_d        = S_REL_RD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/agtq_dp.sv]
// agtq_dp: queue memory, head and count, time difference unit and output stage
// depends on agtq_pkg; commanded by agtq_ctrl
`default_nettype none

module agtq_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  agtq_pkg::cmd_t                       cmd_i,
  output agtq_pkg::sts_t                       sts_o,
  input  agtq_pkg::in_item_t                   in_item_i,
  input  wire logic [agtq_pkg::DELAY_W-1:0]    delay_i,
  input  wire logic [agtq_pkg::LEVEL_W-1:0]    thr_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output agtq_pkg::out_item_t                  out_item_o
);

  localparam int unsigned IW = agtq_pkg::IDX_W;
  localparam int unsigned CW = agtq_pkg::CNT_W;
  localparam int unsigned TW = agtq_pkg::TIME_W;

  agtq_pkg::entry_t   mem_q [agtq_pkg::QUEUE_DEPTH];
  agtq_pkg::entry_t   rd_q;
  agtq_pkg::in_item_t item_q;
  logic [IW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [TW:0]        diff_q, diff_d;
  logic               pend_valid_q, pend_valid_d;
  logic [agtq_pkg::TAG_W-1:0] pend_tag_q, pend_tag_d;
  logic               out_valid_q, out_valid_d;
  agtq_pkg::out_item_t out_q, out_d;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      head_inc;
  logic [CW-1:0]      prev_off;
  logic [TW:0]        item_ext, rd_ext;

  // read address select
  always_comb begin
    prev_off = (count_q >= CW'(2)) ? (count_q - CW'(2)) : '0;
    unique case (cmd_i.rd_sel)
      agtq_pkg::RD_HEAD:   rd_addr = head_q;
      agtq_pkg::RD_NEWEST: rd_addr = agtq_pkg::slot_of(head_q, count_q - CW'(1));
      agtq_pkg::RD_PREV:   rd_addr = agtq_pkg::slot_of(head_q, prev_off);
      default:             rd_addr = head_q;
    endcase
  end

  assign wr_addr  = agtq_pkg::slot_of(head_q, count_q);
  assign head_inc = (head_q == IW'(agtq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[wr_addr] <= '{tag: item_q.buffer_tag, time_ms: item_q.time_ms,
                          level: item_q.level};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    diff_q     <= diff_d;
    pend_tag_q <= pend_tag_d;
    out_q      <= out_d;
  end

  // head and occupancy
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (cmd_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.drop_newest) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.pop_head) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end else if (cmd_i.head_zero) begin
      head_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end
  end

  // time difference unit
  assign item_ext = {1'b0, item_q.time_ms};
  assign rd_ext   = {1'b0, rd_q.time_ms};

  always_comb begin
    diff_d = diff_q;
    if (cmd_i.gap_ld) begin
      diff_d = (item_ext >= rd_ext) ? (item_ext - rd_ext) : (rd_ext - item_ext);
    end else if (cmd_i.rel_ld) begin
      diff_d = item_ext - rd_ext;
    end
  end

  // held release and output stage
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_tag_d   = pend_tag_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    if (cmd_i.emit) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = '{out_tag: pend_tag_q, last_of_run: 1'b0};
      end
      pend_valid_d = 1'b1;
      pend_tag_d   = rd_q.tag;
    end else if (cmd_i.finish && pend_valid_q) begin
      out_valid_d  = 1'b1;
      out_d        = '{out_tag: pend_tag_q, last_of_run: 1'b1};
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign sts_o.count_zero   = (count_q == '0);
  assign sts_o.count_full   = (count_q >= CW'(agtq_pkg::QUEUE_DEPTH));
  assign sts_o.gap          = (diff_q[TW-1:0] > TW'({delay_i, 1'b0}));
  assign sts_o.loud_item    = (item_q.level >= thr_i);
  assign sts_o.newest_quiet = (rd_q.level < thr_i);
  assign sts_o.release_ok   = ~diff_q[TW] & (diff_q[TW-1:0] > TW'(delay_i));
  assign sts_o.out_free     = ~pend_valid_q | ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/audio_gap_trim_delay_queue_core.sv]
// audio_gap_trim_delay_queue_core: top level with register port, controller and datapath
// depends on agtq_pkg, agtq_ctrl and agtq_dp
// a buffer on a non-empty queue runs a gap test, then a push and window releases; a full queue
// forces one out first; a loud gap trims quiet entries and flushes the rest first; a quiet gap
// drops the buffer; a stop empties the queue; output stalls hold the work; one item at a time
// reset empties the queue, sets delay_ms to 3000 and loud_threshold to 512; no clearing pass
`default_nettype none

module audio_gap_trim_delay_queue_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  agtq_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output agtq_pkg::out_item_t                 out_item_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [agtq_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [agtq_pkg::DATA_W-1:0]    pwdata,
  output logic [agtq_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [agtq_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic [agtq_pkg::LEVEL_W-1:0] thr_q, thr_d;
  logic                         cfg_wr;
  agtq_pkg::reg_idx_e           reg_idx;
  agtq_pkg::cmd_t               cmd;
  agtq_pkg::sts_t               sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = agtq_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    delay_d = delay_q;
    thr_d   = thr_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        agtq_pkg::REG_DELAY: delay_d = pwdata[agtq_pkg::DELAY_W-1:0];
        agtq_pkg::REG_THR:   thr_d   = pwdata[agtq_pkg::LEVEL_W-1:0];
        default:             delay_d = delay_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      agtq_pkg::REG_DELAY: prdata = agtq_pkg::DATA_W'(delay_q);
      agtq_pkg::REG_THR:   prdata = agtq_pkg::DATA_W'(thr_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= agtq_pkg::DELAY_RST;
      thr_q   <= agtq_pkg::THR_RST;
    end else begin
      delay_q <= delay_d;
      thr_q   <= thr_d;
    end
  end

  agtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  agtq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .delay_i     (delay_q),
    .thr_i       (thr_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("release issued with no room in output stage");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.count_full)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop_head || cmd.drop_newest) |-> !sts.count_zero)
    else $error("entry removed from empty queue");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !cmd.emit && !cmd.push)
    else $error("queue work while taking a new transfer");

endmodule

`default_nettype wire

[verif/agtq_release_checker.sv]
`timescale 1ns / 1ps
// agtq_release_checker: watches the buffer, release and register ports of the delay queue,
// predicts every release transfer and compares it with what the block hands out
// depends on agtq_pkg
module agtq_release_checker
  import agtq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  in_item_t                 in_item_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  out_item_t                out_item_i,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic                pready_i,
  input  wire logic [ADDR_W-1:0]   paddr_i,
  input  wire logic [DATA_W-1:0]   pwdata_i,
  output int unsigned              fail_count_o,
  output int unsigned              backlog_o,
  output int unsigned              items_seen_o,
  output int unsigned              releases_seen_o
);

  localparam logic KIND_STOP = 1'b1;
  localparam int unsigned PRINT_CAP = 50;

  logic [TAG_W-1:0]   tag_mem   [QUEUE_DEPTH];
  logic [TIME_W-1:0]  time_mem  [QUEUE_DEPTH];
  logic [LEVEL_W-1:0] level_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]   head_q    = '0;
  int unsigned        count_q   = 0;
  logic [DELAY_W-1:0] delay_q   = DELAY_RST;
  logic [LEVEL_W-1:0] thr_q     = THR_RST;

  out_item_t   pending_releases[$];
  int unsigned n_fail    = 0;
  int unsigned n_items   = 0;
  int unsigned n_results = 0;

  function automatic logic [IDX_W-1:0] ring_pos(input int unsigned off);
    return IDX_W'((head_q + off) % QUEUE_DEPTH);
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic release_oldest(inout int unsigned n);
    out_item_t r;
    r.out_tag     = tag_mem[ring_pos(0)];
    r.last_of_run = 1'b0;
    pending_releases.push_back(r);
    head_q = head_q + 1'b1;
    count_q--;
    n++;
  endtask

  task automatic enqueue(input in_item_t it);
    logic [IDX_W-1:0] slot;
    slot = ring_pos(count_q);
    tag_mem[slot]   = it.buffer_tag;
    time_mem[slot]  = it.time_ms;
    level_mem[slot] = it.level;
    count_q++;
  endtask

  task automatic predict_releases(input in_item_t it);
    logic [TIME_W-1:0] newest;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] span;
    bit                gap;
    int unsigned       n;
    n   = 0;
    gap = 1'b0;
    if (it.kind == KIND_STOP) begin
      count_q = 0;
      head_q  = '0;
      return;
    end
    if (count_q > 0) begin
      newest = time_mem[ring_pos(count_q - 1)];
      span   = (it.time_ms >= newest) ? it.time_ms - newest : newest - it.time_ms;
      gap    = span > TIME_W'({delay_q, 1'b0});
    end
    if (gap) begin
      if (it.level >= thr_q) begin
        // quiet tail goes first, then everything left is flushed oldest first
        while (count_q > 0 && level_mem[ring_pos(count_q - 1)] < thr_q) begin
          count_q--;
        end
        while (count_q > 0) begin
          release_oldest(n);
        end
        head_q = '0;
        enqueue(it);
      end
    end else begin
      if (count_q >= QUEUE_DEPTH) begin
        release_oldest(n);
      end
      enqueue(it);
      while (count_q > 0) begin
        oldest = time_mem[ring_pos(0)];
        newest = time_mem[ring_pos(count_q - 1)];
        if (newest >= oldest && (newest - oldest) > TIME_W'(delay_q)) begin
          release_oldest(n);
        end else begin
          break;
        end
      end
    end
    if (n > 0) begin
      pending_releases[pending_releases.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic check_release(input out_item_t got);
    out_item_t want;
    n_results++;
    if (pending_releases.size() == 0) begin
      report_mismatch($sformatf("release of tag %h with none pending", got.out_tag));
      return;
    end
    want = pending_releases.pop_front();
    if (got.out_tag !== want.out_tag) begin
      report_mismatch($sformatf("out_tag %h, expected %h", got.out_tag, want.out_tag));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run %b on tag %h, expected %b",
                                got.last_of_run, got.out_tag, want.last_of_run));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  = '0;
      count_q = 0;
      delay_q = DELAY_RST;
      thr_q   = THR_RST;
      pending_releases.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_release(out_item_i);
      end
      if (in_valid_i && in_ready_i) begin
        n_items++;
        predict_releases(in_item_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[2]))
          REG_DELAY: delay_q = pwdata_i[DELAY_W-1:0];
          REG_THR:   thr_q   = pwdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o    <= n_fail;
    backlog_o       <= pending_releases.size();
    items_seen_o    <= n_items;
    releases_seen_o <= n_results;
  end

endmodule

[verif/tb_audio_gap_trim_delay_queue_core.sv]
`timescale 1ns / 1ps
// tb_audio_gap_trim_delay_queue_core: stimulus and verdict for the delay queue core
// depends on agtq_pkg, audio_gap_trim_delay_queue_core and agtq_release_checker
module tb_audio_gap_trim_delay_queue_core;
  import agtq_pkg::*;

  localparam logic        KIND_BUFFER   = 1'b0;
  localparam logic        KIND_STOP     = 1'b1;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 120;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned backlog;
  int unsigned items_seen;
  int unsigned releases_seen;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned settings_used = 1;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  logic [TIME_W-1:0]  cur_t = '0;
  logic [DELAY_W-1:0] delay_cfg = DELAY_RST;
  logic [LEVEL_W-1:0] thr_cfg = THR_RST;

  audio_gap_trim_delay_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  agtq_release_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_i      (out_item_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .fail_count_o    (fail_count),
    .backlog_o       (backlog),
    .items_seen_o    (items_seen),
    .releases_seen_o (releases_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d releases still pending", cycles, backlog);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: runs of always ready, random stalls and long holds
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(1, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= (rx_left > 12);
    endcase
  end

  function automatic in_item_t item_of(input logic kind, input logic [TAG_W-1:0] tag,
                                       input logic [TIME_W-1:0] t,
                                       input logic [LEVEL_W-1:0] lvl);
    in_item_t it;
    it.kind       = kind;
    it.buffer_tag = tag;
    it.time_ms    = t;
    it.level      = lvl;
    return it;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_for(input bit loud);
    if (loud) begin
      return LEVEL_W'($urandom_range(thr_cfg, 32767));
    end else if (thr_cfg == 0) begin
      return LEVEL_W'($urandom);
    end
    return LEVEL_W'($urandom_range(0, thr_cfg - 1));
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [DELAY_W-1:0] delay, input logic [LEVEL_W-1:0] thr);
    delay_cfg = delay;
    thr_cfg   = thr;
    write_reg(REG_DELAY, DATA_W'(delay));
    write_reg(REG_THR, DATA_W'(thr));
    settings_used++;
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
    end
  endtask

  task automatic transfer_item(input in_item_t it);
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pace_sender();
  endtask

  task automatic drain_queue();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic next_item(output in_item_t it);
    int unsigned        pick;
    int unsigned        shape;
    bit                 loud;
    logic [TIME_W-1:0]  t;
    logic [TIME_W-1:0]  jump;
    logic [LEVEL_W-1:0] lvl;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    loud  = $urandom_range(0, 1);
    lvl   = level_for(loud);
    if (pick < 5) begin
      it = item_of(KIND_STOP, TAG_W'($urandom), TIME_W'({$urandom, $urandom}),
                   LEVEL_W'($urandom));
    end else if (pick < 13) begin
      t  = TIME_W'({$urandom, $urandom});
      it = item_of(KIND_BUFFER, TAG_W'($urandom), t, LEVEL_W'($urandom));
      if ($urandom_range(0, 1) == 1) begin
        cur_t = t;
      end
    end else if (pick < 23) begin
      jump = TIME_W'(delay_cfg) * 2 + TIME_W'($urandom_range(1, 500));
      t    = ($urandom_range(0, 1) == 1) ? cur_t + jump : cur_t - jump;
      it   = item_of(KIND_BUFFER, TAG_W'($urandom), t, lvl);
      if (loud) begin
        cur_t = t;
      end
    end else begin
      if (shape < 7) begin
        t = cur_t + TIME_W'($urandom_range(0, delay_cfg / 40 + 1));
      end else if (shape < 9) begin
        t = cur_t + TIME_W'(delay_cfg) + TIME_W'($urandom_range(0, 2));
      end else begin
        t = cur_t - TIME_W'($urandom_range(0, delay_cfg));
      end
      it    = item_of(KIND_BUFFER, TAG_W'($urandom), t, lvl);
      cur_t = t;
    end
  endtask

  task automatic run_stream(input int unsigned count);
    in_item_t it;
    cur_t = TIME_W'({$urandom, $urandom});
    for (int unsigned i = 0; i < count; i++) begin
      next_item(it);
      transfer_item(it);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window edges, gap edges, threshold edges
    transfer_item(item_of(KIND_BUFFER, 16'h0000, 40'd0, 15'd0));
    transfer_item(item_of(KIND_BUFFER, 16'h0001, 40'd3000, 15'd511));
    transfer_item(item_of(KIND_BUFFER, 16'h0002, 40'd3001, 15'd512));
    transfer_item(item_of(KIND_BUFFER, 16'h0003, 40'd9001, 15'd512));
    transfer_item(item_of(KIND_BUFFER, 16'h0004, 40'd4000, 15'd100));
    transfer_item(item_of(KIND_BUFFER, 16'h0005, 40'd10001, 15'd0));
    transfer_item(item_of(KIND_BUFFER, 16'h0006, 40'd10001, 15'd511));
    transfer_item(item_of(KIND_BUFFER, 16'h0007, 40'd10002, 15'd512));
    transfer_item(item_of(KIND_STOP, 16'h1234, 40'd55, 15'd7));
    transfer_item(item_of(KIND_STOP, '1, '1, '1));
    transfer_item(item_of(KIND_BUFFER, 16'hffff, 40'hff_ffff_ffff, 15'h7fff));
    transfer_item(item_of(KIND_BUFFER, 16'h0008, 40'd0, 15'h7fff));
    transfer_item(item_of(KIND_STOP, 16'h0000, 40'd0, 15'd0));
    transfer_item(item_of(KIND_BUFFER, 16'h0009, 40'd0, 15'd0));
    transfer_item(item_of(KIND_BUFFER, 16'h000a, 40'd10, 15'd5));
    transfer_item(item_of(KIND_BUFFER, 16'h000b, 40'd20, 15'd0));
    transfer_item(item_of(KIND_BUFFER, 16'h000c, 40'd20000, 15'd600));
    transfer_item(item_of(KIND_BUFFER, 16'h5a5a, 40'h80_0000_0000, 15'h4000));
    transfer_item(item_of(KIND_BUFFER, 16'ha5a5, 40'h80_0000_0bb8, 15'h2aaa));
    run_stream(40);

    drain_queue();
    apply_config(16'hffff, 15'h7fff);
    run_stream(40);

    drain_queue();
    apply_config('0, '0);
    run_stream(30);

    drain_queue();
    apply_config(DELAY_W'($urandom_range(20, 4000)), LEVEL_W'($urandom_range(1, 32766)));
    run_stream(42);

    drain_queue();
    $display("covered %0d buffer and stop transfers under %0d register settings",
             items_seen, settings_used);
    $display("%0d release transfers checked, %0d mismatches", releases_seen, fail_count);
    if (fail_count == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
